// ===== hw/rtl/bol_pkg.sv =====
// bol_pkg: shared codes and defaults for the bounded ordered list engine.
// Used by bol_cell, bol_ctrl and bounded_ordered_list_engine_unit. No dependencies.
package bol_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam int FUNC_W   = 4;
  localparam int POS_W    = 7;
  localparam int IO_WORD_W = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // Request codes carried by in_func; codes nine to fifteen are ignored.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 4'd0,
    FN_PUSH_FRONT = 4'd1,
    FN_POP_BACK   = 4'd2,
    FN_POP_FRONT  = 4'd3,
    FN_READ       = 4'd4,
    FN_WRITE      = 4'd5,
    FN_INSERT     = 4'd6,
    FN_ERASE      = 4'd7,
    FN_CLEAR      = 4'd8
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Command broadcast along the cell row.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_WRITE = 2'd1,  // load new word at the addressed cell
    CELL_SHR   = 2'd2,  // open a gap at the addressed cell, load new word there
    CELL_SHL   = 2'd3   // close the gap at the addressed cell
  } cell_op_t;

endpackage

// ===== hw/rtl/bol_cell.sv =====
// bol_cell: one storage cell of the list row; takes its left or right
// neighbor's word, the new word, or holds. Depends on bol_pkg.
module bol_cell #(
  parameter int WORD_BITS = bol_pkg::WORD_BITS_DEF,
  parameter int IW        = 6,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  bol_pkg::cell_op_t     op,
  input  logic [IW-1:0]         op_pos,
  input  logic [WORD_BITS-1:0]  wr_word,
  input  logic [WORD_BITS-1:0]  left_word,
  input  logic [WORD_BITS-1:0]  right_word,
  output logic [WORD_BITS-1:0]  word_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (op)
      bol_pkg::CELL_HOLD: begin
        word_nxt = word_r;
      end
      bol_pkg::CELL_WRITE: begin
        if (op_pos == MY_IDX) word_nxt = wr_word;
      end
      bol_pkg::CELL_SHR: begin
        if (op_pos == MY_IDX) word_nxt = wr_word;
        else if (MY_IDX > op_pos) word_nxt = left_word;
      end
      bol_pkg::CELL_SHL: begin
        if (MY_IDX >= op_pos) word_nxt = right_word;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;

endmodule

// ===== hw/rtl/bol_ctrl.sv =====
// bol_ctrl: request decode; range/full/empty checks, cell row command
// and next count. Depends on bol_pkg.
module bol_ctrl #(
  parameter int CAPACITY = bol_pkg::CAPACITY_DEF,
  parameter int IW       = 6,
  parameter int CW       = 7
) (
  input  logic [bol_pkg::FUNC_W-1:0] func,
  input  logic [bol_pkg::POS_W-1:0]  position,
  input  logic [CW-1:0]              held,
  output bol_pkg::cell_op_t          op,
  output logic [IW-1:0]              op_pos,
  output logic [CW-1:0]              held_nxt,
  output bol_pkg::status_t           status,
  output logic                       rd_en
);

  localparam int PW = (CW > bol_pkg::POS_W) ? CW : bol_pkg::POS_W;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] held_ext;
  logic          full;
  logic          empty;
  logic          in_range;
  logic          ins_ok;

  assign pos_ext  = PW'(position);
  assign held_ext = PW'(held);
  assign full     = (held == CW'(CAPACITY));
  assign empty    = (held == '0);
  assign in_range = (pos_ext < held_ext);
  assign ins_ok   = (pos_ext <= held_ext);

  always_comb begin
    op       = bol_pkg::CELL_HOLD;
    op_pos   = pos_ext[IW-1:0];
    held_nxt = held;
    status   = bol_pkg::ST_OK;
    rd_en    = 1'b0;
    unique case (bol_pkg::func_t'(func))
      bol_pkg::FN_PUSH_BACK: begin
        if (full) status = bol_pkg::ST_FULL;
        else begin
          op       = bol_pkg::CELL_WRITE;
          op_pos   = held_ext[IW-1:0];
          held_nxt = CW'(held + 1'b1);
        end
      end
      bol_pkg::FN_PUSH_FRONT: begin
        if (full) status = bol_pkg::ST_FULL;
        else begin
          op       = bol_pkg::CELL_SHR;
          op_pos   = '0;
          held_nxt = CW'(held + 1'b1);
        end
      end
      bol_pkg::FN_POP_BACK: begin
        if (empty) status = bol_pkg::ST_EMPTY;
        else held_nxt = CW'(held - 1'b1);
      end
      bol_pkg::FN_POP_FRONT: begin
        if (empty) status = bol_pkg::ST_EMPTY;
        else begin
          op       = bol_pkg::CELL_SHL;
          op_pos   = '0;
          held_nxt = CW'(held - 1'b1);
        end
      end
      bol_pkg::FN_READ: begin
        if (!in_range) status = bol_pkg::ST_RANGE;
        else rd_en = 1'b1;
      end
      bol_pkg::FN_WRITE: begin
        if (!in_range) status = bol_pkg::ST_RANGE;
        else op = bol_pkg::CELL_WRITE;
      end
      bol_pkg::FN_INSERT: begin
        // position check comes before the full check
        if (!ins_ok) status = bol_pkg::ST_RANGE;
        else if (full) status = bol_pkg::ST_FULL;
        else begin
          op       = bol_pkg::CELL_SHR;
          held_nxt = CW'(held + 1'b1);
        end
      end
      bol_pkg::FN_ERASE: begin
        if (!in_range) status = bol_pkg::ST_RANGE;
        else begin
          op       = bol_pkg::CELL_SHL;
          held_nxt = CW'(held - 1'b1);
        end
      end
      bol_pkg::FN_CLEAR: begin
        held_nxt = '0;
      end
      default: begin
        op = bol_pkg::CELL_HOLD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bounded_ordered_list_engine_unit.sv =====
// bounded_ordered_list_engine_unit: top level of the ordered list engine.
// Instantiates bol_ctrl and a row of bol_cell; depends on bol_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | to block  | in_valid / in_stall | in_func, in_position, in_value
//  out_    | from block| out_valid/out_stall | out_read_value, out_front_value,
//          |           |                     | out_back_value, out_count, out_status
//
// The accepting edge of an item updates the cell row and the count; the result
// (front/back from the updated row) is then captured into the output register
// when the output can take it. A new item is taken once that capture is done.
// Reset (rst_n low, synchronous) empties the list and drops any pending item;
// cell contents are not cleared, and in_stall stays high while rst_n is low.
// out_stall only delays the capture of the next result; the held result
// stays stable until it is taken.
module bounded_ordered_list_engine_unit #(
  parameter int CAPACITY  = bol_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = bol_pkg::WORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic        [bol_pkg::FUNC_W-1:0]         in_func,
  input  logic        [bol_pkg::POS_W-1:0]          in_position,
  input  logic signed [bol_pkg::IO_WORD_W-1:0]      in_value,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [bol_pkg::IO_WORD_W-1:0]      out_read_value,
  output logic signed [bol_pkg::IO_WORD_W-1:0]      out_front_value,
  output logic signed [bol_pkg::IO_WORD_W-1:0]      out_back_value,
  output logic        [bol_pkg::COUNT_W-1:0]        out_count,
  output logic        [bol_pkg::STATUS_W-1:0]       out_status
);

  localparam int IW = $clog2(CAPACITY);      // cell index width
  localparam int CW = $clog2(CAPACITY + 1);  // count width
  localparam int OW = bol_pkg::IO_WORD_W;

  // Handshake / sequencing
  logic accept;
  logic load;
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;

  // List state
  logic [CW-1:0] held_r, held_nxt;

  // Decode results
  bol_pkg::cell_op_t ctl_op;
  bol_pkg::cell_op_t row_op;
  logic [IW-1:0]     op_pos;
  bol_pkg::status_t  ctl_status;
  logic              rd_en;

  // Per-item results captured at accept
  logic signed [OW-1:0] rd_r;
  bol_pkg::status_t     status_r;

  // Cell row
  logic [WORD_BITS-1:0] wr_word;
  logic [WORD_BITS-1:0] words [CAPACITY];
  logic [CW-1:0]        last_pos;
  logic [IW-1:0]        back_idx;

  // Output register
  logic signed [OW-1:0]            o_read_r, o_front_r, o_back_r;
  logic [bol_pkg::COUNT_W-1:0]     o_count_r;
  logic [bol_pkg::STATUS_W-1:0]    o_status_r;

  // No item is taken while in reset or while one is still pending.
  assign in_stall = pend_r | ~rst_n;
  assign accept   = in_valid & ~in_stall;
  assign load     = pend_r & (~out_valid_r | ~out_stall);

  bol_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .func     (in_func),
    .position (in_position),
    .held     (held_r),
    .op       (ctl_op),
    .op_pos   (op_pos),
    .held_nxt (held_nxt),
    .status   (ctl_status),
    .rd_en    (rd_en)
  );

  // Cells move only on an accepted item.
  assign row_op  = accept ? ctl_op : bol_pkg::CELL_HOLD;
  // Input word: sign-extended or cut to the stored width.
  assign wr_word = WORD_BITS'(in_value);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    // Front cell never takes a left neighbor; last cell never needs a right one.
    if (i == 0) begin : g_first
      assign left_w = wr_word;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    bol_cell #(
      .WORD_BITS (WORD_BITS),
      .IW        (IW),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .op         (row_op),
      .op_pos     (op_pos),
      .wr_word    (wr_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word_o     (words[i])
    );
  end

  assign last_pos = CW'(held_r - 1'b1);
  assign back_idx = last_pos[IW-1:0];

  always_comb begin
    pend_nxt = pend_r;
    if (accept) pend_nxt = 1'b1;
    else if (load) pend_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) held_r <= held_nxt;
    end
  end

  // Read word comes from the row before it changes (a read never changes it).
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r     <= rd_en ? OW'($signed(words[op_pos])) : '0;
      status_r <= ctl_status;
    end
  end

  // Result capture: front/back from the updated row, zero when empty.
  always_ff @(posedge clk) begin
    if (load) begin
      o_read_r   <= rd_r;
      o_front_r  <= (held_r != '0) ? OW'($signed(words[0])) : '0;
      o_back_r   <= (held_r != '0) ? OW'($signed(words[back_idx])) : '0;
      o_count_r  <= bol_pkg::COUNT_W'(held_r);
      o_status_r <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = o_read_r;
  assign out_front_value = o_front_r;
  assign out_back_value  = o_back_r;
  assign out_count       = o_count_r;
  assign out_status      = o_status_r;

endmodule
